@@ sv/delimiter_field_splitter_unit_assert.svh @@
// Assertion shorthands shared by the delimiter field splitter.
// Both forms sample on the rising edge of i_clk and are off while i_rst_n is low.
`ifndef DELIMITER_FIELD_SPLITTER_UNIT_ASSERT_SVH
`define DELIMITER_FIELD_SPLITTER_UNIT_ASSERT_SVH

// Condition that holds at every edge.
`define DFS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication from the trigger to the consequence, in its non-overlapping form.
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/dfs_pkg.sv @@
`default_nettype none

package dfs_pkg;

    // Default sizes.
    localparam int DFS_MAX_FIELDS      = 64;
    localparam int DFS_MAX_FIELD_BYTES = 256;
    localparam int DFS_DELIM_MAX       = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int DLEN_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LENGTH = 1'b1;

    // Delimiter after reset is a single comma.
    localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RESET  = 64'd44;
    localparam logic [DLEN_W-1:0]     DELIM_LENGTH_RESET = 4'd1;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_line;
    } t_in_word;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_byte;
        logic [5:0] field_index;
        logic [7:0] field_length;
        logic [6:0] field_total;
        logic       overflow;
        logic       last_of_run;
    } t_out_word;

    // One slot of the candidate window.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_cell_val;

endpackage

`default_nettype wire

@@ sv/dfs_cell.sv @@
`default_nettype none

module dfs_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [7:0]          i_delim_byte,
    input  wire                 i_left_valid,
    input  wire                 i_append,
    input  wire  [7:0]          i_in_byte,
    input  wire                 i_shift,
    input  dfs_pkg::t_cell_val  i_src,
    output logic                o_st_valid,
    output logic                o_st_match,
    output dfs_pkg::t_cell_val  o_eff,
    output logic                o_eff_match
);
    import dfs_pkg::*;

    logic       r_valid;
    logic [7:0] r_data;
    logic       at_tail;
    t_cell_val  n_val;

    // The incoming byte lands in the first empty slot of the row.
    assign at_tail     = i_append && !r_valid && i_left_valid;
    assign o_eff.valid = r_valid || at_tail;
    assign o_eff.data  = at_tail ? i_in_byte : r_data;
    assign o_eff_match = (o_eff.data == i_delim_byte);
    assign o_st_valid  = r_valid;
    assign o_st_match  = (r_data == i_delim_byte);
    assign n_val       = i_shift ? i_src : o_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_val.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_val.data;
    end

endmodule

`default_nettype wire

@@ sv/delimiter_field_splitter_unit.sv @@
// Splits a byte stream, one line at a time, at a delimiter of one to DELIM_MAX bytes written
// through the configuration port (index 0 holds the delimiter bytes with the first byte in
// bits 7:0, index 1 the length; 0 acts as 1 and lengths above DELIM_MAX act as DELIM_MAX;
// write them only while the block is idle). Each input word carries one byte or an end of line
// mark, and each output word is a data byte, a field end or the final field end of the line,
// with last_of_run set on the last output word caused by an input word. Matches are leftmost
// and non-overlapping. Bytes that may still start a delimiter wait in a row of DELIM_MAX cells,
// each holding one byte, comparing it against its own delimiter byte and handing it down
// the row when the row shifts; they come out as field data as soon as they cannot start a
// match, and the delimiter bytes themselves are dropped. Fields past MAX_FIELDS and bytes past
// MAX_FIELD_BYTES-1 in a field are dropped and the overflow flag is raised for the rest of the
// line. A plain stream runs at one word per cycle while the output does not stall. The row
// makes one decision per cycle while it can go, and every decision that yields a result
// moves exactly one output word, so an input word that releases held bytes or closes several
// fields holds the input stalled until its last decision, and an end of line first releases
// each held byte and then closes the line. Each result passes a hold register, which is
// where last_of_run is settled, and then the output register, so a word may be accepted
// while the output register waits on a stall.
`default_nettype none

`include "delimiter_field_splitter_unit_assert.svh"

module delimiter_field_splitter_unit #(
    parameter int MAX_FIELDS      = dfs_pkg::DFS_MAX_FIELDS,
    parameter int MAX_FIELD_BYTES = dfs_pkg::DFS_MAX_FIELD_BYTES,
    parameter int DELIM_MAX       = dfs_pkg::DFS_DELIM_MAX
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input channel.
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  dfs_pkg::t_in_word                 i_in_word,
    // Output channel.
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output dfs_pkg::t_out_word                o_out_word,
    // Configuration write channel.
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [dfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire  [dfs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import dfs_pkg::*;

    localparam int FW  = $clog2(MAX_FIELDS + 1);
    localparam int LW  = $clog2(MAX_FIELD_BYTES);
    localparam int DBW = DELIM_MAX * 8;

    // Configuration registers. Only the bytes that a delimiter can use are kept.
    logic [DBW-1:0]    r_delim_bytes;
    logic [DLEN_W-1:0] r_delim_len;
    logic [DLEN_W-1:0] len_eff;

    // Line state.
    logic [FW-1:0] r_field;
    logic [LW-1:0] r_length;
    logic          r_ovf;
    logic [FW-1:0] n_field;
    logic [LW-1:0] n_length;
    logic          n_ovf;
    logic [FW-1:0] field_next;

    // Sequencing. r_in_step marks a byte whose scan may still go on; r_flush marks an end of
    // line that is still draining the held bytes.
    logic r_in_step;
    logic r_flush;

    // Result staging: hold register, then output register.
    logic      r_hold_valid;
    t_out_word r_hold;
    logic      r_out_valid;
    t_out_word r_out;

    // Cell row.
    logic [DELIM_MAX-1:0] st_vld;
    logic [DELIM_MAX-1:0] st_mt;
    logic [DELIM_MAX-1:0] eff_mt;
    logic [DELIM_MAX-1:0] left_vld;
    t_cell_val            w_eff [DELIM_MAX];
    t_cell_val            w_src [DELIM_MAX];

    logic pfx_st;
    logic full_st;
    logic pfx_eff;
    logic full_eff;
    logic need_st;

    logic busy;
    logic out_free;
    logic can_go;
    logic in_acc;
    logic go;
    logic line_end;
    logic append;

    logic              act_put;
    logic              act_close;
    logic              act_final;
    logic              shift_len;
    logic              cell_shift;
    logic [DLEN_W-1:0] shamt;

    logic      data_drop;
    logic      field_full;
    logic      res_valid;
    t_out_word res;

    logic      move_last;
    logic      move_mid;
    logic      out_load;
    t_out_word out_next;

    // ------------------------------------------------------------------
    // Configuration. The port never pushes back.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim_bytes <= DELIM_BYTES_RESET[DBW-1:0];
            r_delim_len   <= DELIM_LENGTH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DELIM_BYTES: begin
                    r_delim_bytes <= i_cfg_data[DBW-1:0];
                end
                CFG_DELIM_LENGTH: begin
                    r_delim_len <= i_cfg_data[DLEN_W-1:0];
                end
            endcase
        end
    end

    // Length in use, clamped into 1..DELIM_MAX.
    always_comb begin
        if (r_delim_len == '0) begin
            len_eff = DLEN_W'(1);
        end else if (r_delim_len > DLEN_W'(DELIM_MAX)) begin
            len_eff = DLEN_W'(DELIM_MAX);
        end else begin
            len_eff = r_delim_len;
        end
    end

    // ------------------------------------------------------------------
    // Cell row. Cell i holds the i-th held byte and compares it with the i-th delimiter byte.
    // ------------------------------------------------------------------
    always_comb begin
        left_vld[0] = 1'b1;
        for (int i = 1; i < DELIM_MAX; i++) begin
            left_vld[i] = st_vld[i-1];
        end
    end

    // A release moves the row down by one slot, a match by the delimiter length.
    assign cell_shift = act_put || act_close;
    assign shamt      = shift_len ? len_eff : DLEN_W'(1);

    always_comb begin
        for (int i = 0; i < DELIM_MAX; i++) begin
            w_src[i] = '0;
            for (int j = i + 1; j < DELIM_MAX; j++) begin
                if (shamt == DLEN_W'(j - i)) begin
                    w_src[i] = w_eff[j];
                end
            end
        end
    end

    for (genvar g = 0; g < DELIM_MAX; g++) begin : g_cell
        dfs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_delim_byte (r_delim_bytes[g*8 +: 8]),
            .i_left_valid (left_vld[g]),
            .i_append     (append),
            .i_in_byte    (i_in_word.in_byte),
            .i_shift      (cell_shift),
            .i_src        (w_src[g]),
            .o_st_valid   (st_vld[g]),
            .o_st_match   (st_mt[g]),
            .o_eff        (w_eff[g]),
            .o_eff_match  (eff_mt[g])
        );
    end

    // The held bytes still look like the start of the delimiter (prefix), and there are enough
    // of them to hold all of it (full). The stored view steers the handshake; the view with the
    // arriving byte in place steers the decision.
    always_comb begin
        pfx_st   = 1'b1;
        pfx_eff  = 1'b1;
        full_st  = 1'b0;
        full_eff = 1'b0;
        for (int i = 0; i < DELIM_MAX; i++) begin
            if (DLEN_W'(i) < len_eff) begin
                if (st_vld[i] && !st_mt[i]) begin
                    pfx_st = 1'b0;
                end
                if (w_eff[i].valid && !eff_mt[i]) begin
                    pfx_eff = 1'b0;
                end
            end
            if (DLEN_W'(i) + DLEN_W'(1) == len_eff) begin
                full_st  = st_vld[i];
                full_eff = w_eff[i].valid;
            end
        end
    end

    // The scan of a byte goes on while the row can release or match again.
    assign need_st = st_vld[0] && (!pfx_st || full_st);

    // ------------------------------------------------------------------
    // Handshake and sequencing.
    // ------------------------------------------------------------------
    assign busy       = r_flush || (r_in_step && need_st);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign can_go     = !r_hold_valid || out_free;
    assign o_in_stall = busy || !can_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign go         = can_go && (busy || in_acc);
    assign line_end   = r_flush || (in_acc && i_in_word.end_of_line);
    assign append     = in_acc && !i_in_word.end_of_line;

    // One decision per cycle while the block can go: release the front byte, close a field on a full
    // match, close the line, or keep waiting for more bytes.
    always_comb begin
        act_put   = 1'b0;
        act_close = 1'b0;
        act_final = 1'b0;
        shift_len = 1'b0;
        if (go) begin
            if (line_end) begin
                if (w_eff[0].valid) begin
                    act_put = 1'b1;
                end else begin
                    act_final = 1'b1;
                end
            end else if (w_eff[0].valid) begin
                if (pfx_eff && full_eff) begin
                    act_close = 1'b1;
                    shift_len = 1'b1;
                end else if (!pfx_eff) begin
                    act_put = 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Field bookkeeping and result word.
    // ------------------------------------------------------------------
    assign field_full = (r_field >= FW'(MAX_FIELDS));
    assign data_drop  = field_full || (r_length >= LW'(MAX_FIELD_BYTES - 1));
    assign field_next = r_field + FW'(1);

    always_comb begin
        n_field   = r_field;
        n_length  = r_length;
        n_ovf     = r_ovf;
        res_valid = 1'b0;
        res       = '0;
        res.out_kind = KIND_DATA;
        res.overflow = r_ovf;
        if (act_put) begin
            if (data_drop) begin
                n_ovf = 1'b1;
            end else begin
                res_valid       = 1'b1;
                res.out_byte    = w_eff[0].data;
                res.field_index = 6'(r_field);
                n_length        = r_length + LW'(1);
            end
        end else if (act_close) begin
            if (field_full) begin
                n_ovf = 1'b1;
            end else begin
                res_valid        = 1'b1;
                res.out_kind     = KIND_FIELD_END;
                res.field_index  = 6'(r_field);
                res.field_length = 8'(r_length);
                n_field          = field_next;
                n_length         = '0;
            end
        end else if (act_final) begin
            // The line always ends with a result; a line with too many fields reports the
            // last field slot as empty and the ceiling as the total.
            res_valid    = 1'b1;
            res.out_kind = KIND_LINE_END;
            if (field_full) begin
                res.field_index = 6'(MAX_FIELDS - 1);
                res.field_total = 7'(MAX_FIELDS);
                res.overflow    = 1'b1;
            end else begin
                res.field_index  = 6'(r_field);
                res.field_length = 8'(r_length);
                res.field_total  = 7'(field_next);
            end
            n_field  = '0;
            n_length = '0;
            n_ovf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field   <= '0;
            r_length  <= '0;
            r_ovf     <= 1'b0;
            r_in_step <= 1'b0;
            r_flush   <= 1'b0;
        end else begin
            r_field  <= n_field;
            r_length <= n_length;
            r_ovf    <= n_ovf;
            if (go) begin
                r_in_step <= !line_end;
                r_flush   <= line_end && act_put;
            end else if (!busy) begin
                r_in_step <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result staging. A result waits in the hold register until it is known whether its input
    // word causes another one; it then leaves with last_of_run cleared when the next one
    // arrives, or set once the scan of its input word is over.
    // ------------------------------------------------------------------
    assign move_last = !busy && r_hold_valid && out_free;
    assign move_mid  = busy && go && res_valid && r_hold_valid;
    assign out_load  = move_last || move_mid;

    always_comb begin
        out_next             = r_hold;
        out_next.last_of_run = move_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (go && res_valid) begin
                r_hold_valid <= 1'b1;
            end else if (move_last) begin
                r_hold_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && res_valid) begin
            r_hold <= res;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `DFS_ASSERT_ALWAYS(a_row_packed, ((st_vld & (st_vld + 1'b1)) == '0), "held bytes not packed at the front of the row")
    `DFS_ASSERT_ALWAYS(a_counts_bounded, (r_length <= LW'(MAX_FIELD_BYTES - 1)) && (r_field <= FW'(MAX_FIELDS)), "field counters beyond their limits")
    `DFS_ASSERT_NEXT(a_line_end_clears, act_final, (r_field == '0) && (r_length == '0) && !r_ovf && !r_flush && !st_vld[0], "line state not cleared after the line end")
    `DFS_ASSERT_NEXT(a_mid_keeps_hold, move_mid, r_hold_valid && r_out_valid && !r_out.last_of_run, "result sent before the following one was staged")

endmodule

`default_nettype wire

@@ verif/delimiter_field_splitter_unit_tb.sv @@
`timescale 1ns / 100ps

module delimiter_field_splitter_unit_tb;

    import dfs_pkg::*;

    // A generous ceiling on the run. The slowest legal run with every word
    // giving eight results that each sit out a full stall stays far below it.
    localparam int CYCLE_LIMIT  = 800_000;
    // Cycles to let pass after the last awaited result before touching the
    // delimiter registers or ending the run. A word may keep the row busy
    // for up to eight decisions plus the two register stages without
    // producing any result.
    localparam int SETTLE_WAIT  = 24;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_OFF_LEN = 200;

    typedef enum logic [1:0] {
        ROW_WORD,
        ROW_SET_BYTES,
        ROW_SET_LENGTH
    } t_row_op;

    // One row of the directed table. A row either offers one input word or
    // writes one delimiter register. Where the result can be read off by
    // eye, it is typed into the row and takes the place of the prediction.
    typedef struct {
        t_row_op    op;
        logic [7:0] in_byte;
        logic       end_of_line;
        logic [63:0] reg_value;
        bit         fixed;
        t_out_word  result;
    } t_stim_row;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    t_in_word               in_word   = '0;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;
    logic      cfg_ready;

    delimiter_field_splitter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the splitter: the delimiter registers, the window of held
    // candidate bytes and the per-line field counters.
    // ------------------------------------------------------------------
    logic [63:0] delim_shadow = DELIM_BYTES_RESET;
    logic [3:0]  dlen_shadow  = DELIM_LENGTH_RESET;
    logic [7:0]  held_bytes [8];
    int          held_count    = 0;
    int          field_no      = 0;
    int          field_kept    = 0;
    bit          line_overflow = 1'b0;

    // Results of the word being predicted, and the results still owed by
    // the block, oldest first.
    t_out_word   step_words [$];
    t_out_word   awaited_words [$];

    int          mismatch_count = 0;
    int          words_offered  = 0;
    int          cycle_count    = 0;
    bit          calm           = 1'b0;
    bit          hold_off_req   = 1'b0;
    t_stim_row   plan [$];

    // Delimiter length in force: zero counts as one, and anything past the
    // row size counts as the row size.
    function automatic int delim_span();
        int n;
        n = dlen_shadow;
        if (n == 0) n = 1;
        if (n > DFS_DELIM_MAX) n = DFS_DELIM_MAX;
        return n;
    endfunction

    function automatic void emit_word(t_kind kind, logic [7:0] b, int idx, int len, int tot);
        t_out_word w;
        w.out_kind     = kind;
        w.out_byte     = b;
        w.field_index  = 6'(idx);
        w.field_length = 8'(len);
        w.field_total  = 7'(tot);
        w.overflow     = line_overflow;
        w.last_of_run  = 1'b0;
        step_words.push_back(w);
    endfunction

    // A byte lands in the current field unless the field is full or the
    // line already has its full count of fields.
    function automatic void keep_byte(logic [7:0] b);
        if (field_no >= DFS_MAX_FIELDS || field_kept >= DFS_MAX_FIELD_BYTES - 1) begin
            line_overflow = 1'b1;
        end else begin
            emit_word(KIND_DATA, b, field_no, 0, 0);
            field_kept++;
        end
    endfunction

    function automatic void close_field();
        if (field_no >= DFS_MAX_FIELDS) begin
            line_overflow = 1'b1;
        end else begin
            emit_word(KIND_FIELD_END, 8'h00, field_no, field_kept, 0);
            field_no++;
            field_kept = 0;
        end
    endfunction

    function automatic void shift_held(int n);
        int i;
        for (i = 0; i + n < held_count; i++) held_bytes[i] = held_bytes[i + n];
        held_count -= n;
    endfunction

    // Works out every result that one accepted input word causes, in order,
    // and leaves them in step_words with the run marker on the last one.
    function automatic void split_step(logic [7:0] b, logic eol);
        int  span;
        int  i;
        bit  is_prefix;
        bit  settled;
        span = delim_span();
        step_words.delete();
        if (eol) begin
            for (i = 0; i < held_count; i++) keep_byte(held_bytes[i]);
            held_count = 0;
            if (field_no < DFS_MAX_FIELDS) begin
                emit_word(KIND_LINE_END, 8'h00, field_no, field_kept, field_no + 1);
            end else begin
                line_overflow = 1'b1;
                emit_word(KIND_LINE_END, 8'h00, DFS_MAX_FIELDS - 1, 0, DFS_MAX_FIELDS);
            end
            field_no      = 0;
            field_kept    = 0;
            line_overflow = 1'b0;
        end else begin
            if (held_count < 8) begin
                held_bytes[held_count] = b;
                held_count++;
            end
            settled = 1'b0;
            while (held_count > 0 && !settled) begin
                is_prefix = 1'b1;
                for (i = 0; i < held_count && i < span; i++) begin
                    if (held_bytes[i] != delim_shadow[8*i +: 8]) is_prefix = 1'b0;
                end
                if (is_prefix && held_count >= span) begin
                    close_field();
                    shift_held(span);
                end else if (!is_prefix || held_count >= span) begin
                    keep_byte(held_bytes[0]);
                    shift_held(1);
                end else begin
                    settled = 1'b1;
                end
            end
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking. Every accepted output word is held against the
    // oldest awaited one, field by field.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && !out_stall) begin
            if (awaited_words.size() == 0) begin
                $display("%0t: unexpected output word %0h", $time, out_word);
                mismatch_count++;
            end else begin
                want = awaited_words.pop_front();
                check_field("out_kind", want.out_kind, out_word.out_kind);
                check_field("out_byte", want.out_byte, out_word.out_byte);
                check_field("field_index", want.field_index, out_word.field_index);
                check_field("field_length", want.field_length, out_word.field_length);
                check_field("field_total", want.field_total, out_word.field_total);
                check_field("overflow", want.overflow, out_word.overflow);
                check_field("last_of_run", want.last_of_run, out_word.last_of_run);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("delimiter_field_splitter_unit test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Output side. Before each result the receiver sits out a random number
    // of stalled cycles, except in calm stretches. Once, on request, it
    // stalls for a long stretch so that the block backs up into its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int wait_cycles;
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_LEN) @(negedge clk);
            end
            wait_cycles = calm ? 0 : $urandom_range(0, 14);
            if (wait_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offers one word after a random gap and returns at the edge that takes
    // it. The payload is set together with valid and stays put while stalled.
    task automatic send_word(input logic [7:0] b, input logic eol);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid            <= 1'b1;
        in_word.in_byte     <= b;
        in_word.end_of_line <= eol;
        do @(posedge clk); while (in_stall);
    endtask

    // Sends a word and books what it owes: the prediction, or the single
    // result typed into a directed row.
    task automatic offer_row(input logic [7:0] b, input logic eol, input bit fixed,
                             input t_out_word known);
        send_word(b, eol);
        split_step(b, eol);
        if (fixed) begin
            awaited_words.push_back(known);
        end else begin
            foreach (step_words[i]) awaited_words.push_back(step_words[i]);
        end
        words_offered++;
    endtask

    task automatic offer(input logic [7:0] b, input logic eol);
        offer_row(b, eol, 1'b0, '0);
    endtask

    // Drops valid and waits until the block owes nothing and has had time
    // to finish any word that gives no result.
    task automatic go_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0) @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_DELIM_BYTES) delim_shadow = value;
        else dlen_shadow = value[3:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A field byte for random lines: often one of the delimiter bytes, so
    // that partial and overlapping matches are frequent.
    function automatic logic [7:0] pick_byte(int span);
        if ($urandom_range(0, 9) < 5) return delim_shadow[8*$urandom_range(0, span - 1) +: 8];
        return 8'($urandom);
    endfunction

    // A well-formed line with random content. Now and then a delimiter is
    // cut short, and an open line is left unterminated so that the next
    // delimiter change finds bytes still held.
    task automatic offer_line(input int nfields, input bit closed);
        int span;
        int f;
        int n;
        int j;
        int cut;
        span = delim_span();
        for (f = 0; f < nfields; f++) begin
            n = $urandom_range(0, 6);
            for (j = 0; j < n; j++) offer(pick_byte(span), 1'b0);
            if (f < nfields - 1) begin
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, span - 1) : span;
                for (j = 0; j < cut; j++) offer(delim_shadow[8*j +: 8], 1'b0);
            end
        end
        if (closed) offer(8'($urandom), 1'b1);
    endtask

    // Any byte but the first delimiter byte; only used with a one-byte
    // delimiter.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        if (b == delim_shadow[7:0]) b = ~b;
        return b;
    endfunction

    function automatic t_stim_row word_row(logic [7:0] b, logic eol);
        t_stim_row r;
        r.op          = ROW_WORD;
        r.in_byte     = b;
        r.end_of_line = eol;
        r.reg_value   = '0;
        r.fixed       = 1'b0;
        r.result      = '0;
        return r;
    endfunction

    function automatic t_stim_row known_row(logic [7:0] b, logic eol, t_kind kind,
                                            logic [7:0] ob, int idx, int len, int tot);
        t_stim_row r;
        r = word_row(b, eol);
        r.fixed               = 1'b1;
        r.result.out_kind     = kind;
        r.result.out_byte     = ob;
        r.result.field_index  = 6'(idx);
        r.result.field_length = 8'(len);
        r.result.field_total  = 7'(tot);
        r.result.overflow     = 1'b0;
        r.result.last_of_run  = 1'b1;
        return r;
    endfunction

    function automatic t_stim_row reg_row(t_row_op op, logic [63:0] value);
        t_stim_row r;
        r = word_row(8'h00, 1'b0);
        r.op        = op;
        r.reg_value = value;
        return r;
    endfunction

    initial begin : stimulus
        int          ph;
        int          j;
        int          target;
        logic [7:0]  sym_a;
        logic [7:0]  sym_b;
        logic [63:0] bytes_pick;
        logic [63:0] lengths [8];

        // Synchronous reset at the start of the run, never asserted again.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. After reset the delimiter is a single comma (8'h2c).
        plan.push_back(known_row(8'h00, 1'b1, KIND_LINE_END, 8'h00, 0, 0, 1));
        plan.push_back(known_row(8'h61, 1'b0, KIND_DATA, 8'h61, 0, 0, 0));
        plan.push_back(known_row(8'h2c, 1'b0, KIND_FIELD_END, 8'h00, 0, 1, 0));
        plan.push_back(known_row(8'h2c, 1'b0, KIND_FIELD_END, 8'h00, 1, 0, 0));
        plan.push_back(known_row(8'hff, 1'b0, KIND_DATA, 8'hff, 2, 0, 0));
        plan.push_back(known_row(8'h5a, 1'b1, KIND_LINE_END, 8'h00, 2, 1, 3));
        // Three-byte delimiter "abc". A held "a" is let go by a byte that
        // breaks the match, and "aabc" gives one data byte and then a match.
        plan.push_back(reg_row(ROW_SET_BYTES, 64'h0000_0000_0063_6261));
        plan.push_back(reg_row(ROW_SET_LENGTH, 64'd3));
        plan.push_back(word_row(8'h61, 1'b0));
        plan.push_back(word_row(8'h78, 1'b0));
        plan.push_back(word_row(8'h61, 1'b0));
        plan.push_back(word_row(8'h61, 1'b0));
        plan.push_back(word_row(8'h62, 1'b0));
        plan.push_back(word_row(8'h63, 1'b0));
        // Leave "ab" held, then shrink the delimiter to one byte mid-line
        // (length zero acts as one): the window is re-examined on the next
        // byte.
        plan.push_back(word_row(8'h61, 1'b0));
        plan.push_back(word_row(8'h62, 1'b0));
        plan.push_back(reg_row(ROW_SET_LENGTH, 64'd0));
        plan.push_back(word_row(8'h7a, 1'b0));
        plan.push_back(word_row(8'h00, 1'b1));
        // Eight 8'hff bytes as delimiter via an oversized length. Seven held
        // bytes flushed at end of line give the most results a word can cause.
        plan.push_back(reg_row(ROW_SET_BYTES, '1));
        plan.push_back(reg_row(ROW_SET_LENGTH, 64'd15));
        for (j = 0; j < 7; j++) plan.push_back(word_row(8'hff, 1'b0));
        plan.push_back(word_row(8'hff, 1'b1));

        foreach (plan[r]) begin
            case (plan[r].op)
                ROW_WORD: begin
                    offer_row(plan[r].in_byte, plan[r].end_of_line, plan[r].fixed,
                              plan[r].result);
                end
                ROW_SET_BYTES: begin
                    go_quiet();
                    write_reg(CFG_DELIM_BYTES, plan[r].reg_value);
                end
                default: begin
                    go_quiet();
                    write_reg(CFG_DELIM_LENGTH, plan[r].reg_value);
                end
            endcase
        end

        // Random part, in phases with a fresh delimiter each. The lengths
        // run over the edges: zero and fifteen stand in for one and eight.
        lengths = '{64'd1, 64'd2, 64'd8, 64'd0, 64'd15, 64'd5, 64'd3,
                    64'($urandom_range(0, 15))};
        for (ph = 0; ph < 8; ph++) begin
            go_quiet();
            if (ph == 0) begin
                bytes_pick = {$urandom, $urandom};
            end else if (ph == 3) begin
                bytes_pick = '0;
            end else if (ph == 4) begin
                bytes_pick = '1;
            end else begin
                // Two symbols only, so that delimiters repeat within
                // themselves and the window has to slide over false starts.
                sym_a = 8'($urandom);
                sym_b = 8'($urandom);
                for (j = 0; j < 8; j++) bytes_pick[8*j +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            end
            write_reg(CFG_DELIM_BYTES, bytes_pick);
            write_reg(CFG_DELIM_LENGTH, lengths[ph]);
            calm = (ph % 3 == 1);

            if (ph == 0) begin
                // The receiver holds off while the sender pours in a line
                // with more fields than the block keeps; the block fills
                // and stalls its input.
                calm         = 1'b1;
                hold_off_req = 1'b1;
                for (j = 0; j < DFS_MAX_FIELDS + 4; j++) begin
                    if ($urandom_range(0, 1)) offer(plain_byte(), 1'b0);
                    offer(delim_shadow[7:0], 1'b0);
                end
                offer(plain_byte(), 1'b0);
                offer(8'($urandom), 1'b1);
                calm = 1'b0;
                // A field longer than the block keeps, followed by one more
                // field on the same line, which still carries the flag.
                for (j = 0; j < DFS_MAX_FIELD_BYTES + 2; j++) offer(plain_byte(), 1'b0);
                offer(delim_shadow[7:0], 1'b0);
                offer(plain_byte(), 1'b0);
                offer(8'($urandom), 1'b1);
            end

            target = words_offered + 28;
            while (words_offered < target) begin
                if ($urandom_range(0, 7) == 0) begin
                    offer(8'($urandom), $urandom_range(0, 3) == 0);
                end else begin
                    offer_line($urandom_range(0, 5), $urandom_range(0, 5) != 0);
                end
            end
        end
        offer(8'($urandom), 1'b1);

        go_quiet();
        if (mismatch_count == 0) begin
            $display("delimiter_field_splitter_unit test passed");
        end else begin
            $display("delimiter_field_splitter_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/dfs_pkg.sv
sv/dfs_cell.sv
sv/delimiter_field_splitter_unit.sv
verif/delimiter_field_splitter_unit_tb.sv
